FILE: rtl/sma_pkg.sv
// sma_pkg: opcodes, result status codes and sequencer states for the stack
// machine alu; no dependencies
package sma_pkg;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POP  = 3'd5,
    OP_HALT = 3'd6
  } func_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_UNDER  = 3'd1,
    ST_OVER   = 3'd2,
    ST_DIVZ   = 3'd3,
    ST_HALTED = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_WB
  } state_e;

endpackage

FILE: rtl/stack_machine_alu.sv
// stack_machine_alu: stack machine instruction unit with the stack in a
// single-port synchronous ram and the top entry cached in a register
// depends on sma_pkg
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o   | func_i, operand_i
//  out     | output    | out_valid_o / out_stall_i | popped_valid_o, popped_value_o,
//          |           |                           | status_o, halted_o, depth_now_o
//
// steps: one item at a time; push, halt, a pop that empties the stack and every
//   item rejected before the operand fetch are done in the idle state,
//   a pop that leaves entries and every binary op make one ram read of the entry
//   below the top, which is all that add/sub and a divide by zero need;
//   mul adds one step per digit, ceil(WORD_BITS/16) of them for wide words and one
//   up to 32 bits; div adds WORD_BITS steps, one quotient bit per cycle in the divider
// reset: asynchronous, clears depth, halt flag and sequencer; the ram is not cleared
// stalls: the result sits in an output register; a new item is taken once that
//   register is empty or being drained in the same cycle
module stack_machine_alu #(
  parameter int STACK_DEPTH = 256,
  parameter int WORD_BITS   = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // instruction items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] operand_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               popped_valid_o,
  output logic signed [31:0] popped_value_o,
  output logic [2:0]         status_o,
  output logic               halted_o,
  output logic [8:0]         depth_now_o
);

  import sma_pkg::*;

  localparam int AW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW     = $clog2(STACK_DEPTH + 1);
  localparam int W      = WORD_BITS;
  // multiplier digit: whole word when narrow, 16-bit digits for wide words
  localparam int MD     = (WORD_BITS > 32) ? 16 : WORD_BITS;
  localparam int MSTEPS = (WORD_BITS + MD - 1) / MD;
  localparam int CW     = $clog2(WORD_BITS);

  // stack ram
  logic [W-1:0]  mem [STACK_DEPTH];
  logic [W-1:0]  rdata_q;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  logic [W-1:0]  mem_wd;

  // control state
  state_e        state_q, state_d;
  logic [DW-1:0] depth_q, depth_d;
  logic          halt_q, halt_d;
  logic          out_valid_q, out_valid_d;

  // datapath state
  logic [W-1:0]  tos_q, tos_d;      // copy of the top entry while depth > 0
  func_e         op_q, op_d;
  logic [W-1:0]  a_q, a_d;          // left operand / dividend and quotient
  logic [W-1:0]  b_q, b_d;          // right operand digits / divisor magnitude
  logic [W-1:0]  acc_q, acc_d;      // product sum / partial remainder
  logic          neg_q, neg_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // output register
  logic          pv_q, pv_d;
  logic [31:0]   pval_q, pval_d;
  status_e       status_q, status_d;
  logic          halted_q, halted_d;
  logic [8:0]    dnow_q, dnow_d;

  // combinational helpers
  logic            out_free;
  logic            emit;
  logic            commit;
  status_e         st;
  logic [W-1:0]    pop_word;
  logic [W-1:0]    res;
  logic [W-1:0]    lhs;
  logic [W-1:0]    rhs;
  logic [63:0]     imm_ext;
  logic [W-1:0]    imm;
  logic [DW-1:0]   depth_m2;
  logic [W+MD-1:0] mprod;
  logic [W-1:0]    rem_sh;
  logic            ge;
  logic [W+31:0]   pop_ext;
  logic [DW+8:0]   depth_ext;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);

  assign imm_ext  = {{32{operand_i[31]}}, operand_i};
  assign imm      = imm_ext[W-1:0];
  assign depth_m2 = depth_q - DW'(2);
  assign lhs      = rdata_q;
  assign rhs      = tos_q;

  // one multiplier digit per cycle, product cut to the word
  assign mprod  = a_q * b_q[MD-1:0];
  // restoring divider step
  assign rem_sh = {acc_q[W-2:0], a_q[W-1]};
  assign ge     = (rem_sh >= b_q);

  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    halt_d      = halt_q;
    out_valid_d = out_valid_q && out_stall_i;
    tos_d       = tos_q;
    op_d        = op_q;
    a_d         = a_q;
    b_d         = b_q;
    acc_d       = acc_q;
    neg_d       = neg_q;
    cnt_d       = cnt_q;
    res         = acc_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = depth_m2[AW-1:0];
    mem_wd      = res;
    emit        = 1'b0;
    commit      = 1'b0;
    st          = ST_OK;
    pop_word    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && out_free) begin
          if (halt_q) begin
            emit = 1'b1;
            st   = ST_HALTED;
          end else begin
            case (func_e'(func_i))
              OP_PUSH: begin
                emit = 1'b1;
                if (depth_q == DW'(STACK_DEPTH)) begin
                  st = ST_OVER;
                end else begin
                  mem_we   = 1'b1;
                  mem_addr = depth_q[AW-1:0];
                  mem_wd   = imm;
                  tos_d    = imm;
                  depth_d  = depth_q + DW'(1);
                end
              end
              OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (depth_q < DW'(2)) begin
                  emit = 1'b1;
                  st   = ST_UNDER;
                end else begin
                  // fetch the left operand, the right one is the cached top
                  mem_re  = 1'b1;
                  op_d    = func_e'(func_i);
                  state_d = S_EXEC;
                end
              end
              OP_POP: begin
                emit = 1'b1;
                if (depth_q == '0) begin
                  st = ST_UNDER;
                end else begin
                  pop_word = tos_q;
                  depth_d  = depth_q - DW'(1);
                  if (depth_q >= DW'(2)) begin
                    // refill the cached top from the entry below
                    mem_re  = 1'b1;
                    state_d = S_FILL;
                  end
                end
              end
              OP_HALT: begin
                emit   = 1'b1;
                halt_d = 1'b1;
              end
              default: begin
                emit = 1'b1;
              end
            endcase
          end
        end
      end

      S_FILL: begin
        tos_d   = rdata_q;
        state_d = S_IDLE;
      end

      S_EXEC: begin
        case (op_q)
          OP_ADD: begin
            res    = lhs + rhs;
            commit = 1'b1;
          end
          OP_SUB: begin
            res    = lhs - rhs;
            commit = 1'b1;
          end
          OP_MUL: begin
            a_d     = lhs;
            b_d     = rhs;
            acc_d   = '0;
            cnt_d   = '0;
            state_d = S_MUL;
          end
          OP_DIV: begin
            if (rhs == '0) begin
              emit    = 1'b1;
              st      = ST_DIVZ;
              state_d = S_IDLE;
            end else begin
              a_d     = lhs[W-1] ? (~lhs + W'(1)) : lhs;
              b_d     = rhs[W-1] ? (~rhs + W'(1)) : rhs;
              neg_d   = lhs[W-1] ^ rhs[W-1];
              acc_d   = '0;
              cnt_d   = '0;
              state_d = S_DIV;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_MUL: begin
        acc_d = acc_q + mprod[W-1:0];
        a_d   = a_q << MD;
        b_d   = b_q >> MD;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(MSTEPS - 1)) begin
          state_d = S_WB;
        end
      end

      S_DIV: begin
        acc_d = ge ? (rem_sh - b_q) : rem_sh;
        a_d   = {a_q[W-2:0], ge};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(W - 1)) begin
          state_d = S_WB;
        end
      end

      S_WB: begin
        if (op_q == OP_DIV) begin
          res = neg_q ? (~a_q + W'(1)) : a_q;
        end else begin
          res = acc_q;
        end
        commit = 1'b1;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    // binary op result replaces the left operand and becomes the top
    if (commit) begin
      mem_we   = 1'b1;
      mem_addr = depth_m2[AW-1:0];
      mem_wd   = res;
      tos_d    = res;
      depth_d  = depth_q - DW'(1);
      emit     = 1'b1;
      state_d  = S_IDLE;
    end

    pop_ext   = {32'd0, pop_word};
    depth_ext = {9'd0, depth_d};
    pv_d      = pv_q;
    pval_d    = pval_q;
    status_d  = status_q;
    halted_d  = halted_q;
    dnow_d    = dnow_q;
    if (emit) begin
      out_valid_d = 1'b1;
      pv_d        = (state_q == S_IDLE) && (func_e'(func_i) == OP_POP) &&
                    !halt_q && (st == ST_OK);
      pval_d      = pop_ext[31:0];
      status_d    = st;
      halted_d    = halt_d;
      dnow_d      = depth_ext[8:0];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      halt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      halt_q      <= halt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tos_q    <= tos_d;
    op_q     <= op_d;
    a_q      <= a_d;
    b_q      <= b_d;
    acc_q    <= acc_d;
    neg_q    <= neg_d;
    cnt_q    <= cnt_d;
    pv_q     <= pv_d;
    pval_q   <= pval_d;
    status_q <= status_d;
    halted_q <= halted_d;
    dnow_q   <= dnow_d;
  end

  // single-port stack ram, registered read data
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end else if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign popped_valid_o = pv_q;
  assign popped_value_o = pval_q;
  assign status_o       = status_q;
  assign halted_o       = halted_q;
  assign depth_now_o    = dnow_q;

`ifndef NO_ASSERTIONS
  // stack never grows past its capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  // halt is sticky
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared");

  // a binary op only runs with two entries on the stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC || state_q == S_MUL || state_q == S_DIV || state_q == S_WB)
      |-> depth_q >= DW'(2))
    else $error("binary op with fewer than two entries");

  // a new result never lands on one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && state_q != S_IDLE) |-> !emit)
    else $error("result register overwritten");
`endif

endmodule
